/* rtl/lmdc_pkg.sv */
`timescale 1ns / 1ps

package lmdc_pkg;

  localparam int ENERGY_BITS = 48;
  localparam int COUNT_BITS  = 16;
  localparam int MAXIT_BITS  = 16;
  localparam int TOL_BITS    = 47;
  localparam int CFG_BITS    = 47;
  localparam int DAMP_BITS   = 4;
  localparam int ITER_BITS   = 16;
  localparam int IN_DATA_BITS  = ((ENERGY_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = 32;

  // absolute difference of two signed energies needs one extra bit
  localparam int DIFF_BITS = ENERGY_BITS + 1;

  // iteration count and limit are compared at the wider of the two widths
  localparam int CMP_BITS = (COUNT_BITS > MAXIT_BITS) ? COUNT_BITS : MAXIT_BITS;

  localparam logic [DAMP_BITS-1:0] DAMP_NONE  = 4'd0;
  localparam logic [DAMP_BITS-1:0] DAMP_START = 4'd1;
  localparam logic [DAMP_BITS-1:0] DAMP_MAX   = 4'd13;

  localparam logic [MAXIT_BITS-1:0] MAXIT_RESET = 16'd10;
  localparam logic [TOL_BITS-1:0]   TOL_RESET   = 47'd655;

  typedef enum logic {
    REQ_RESTART = 1'b0,
    REQ_TEST    = 1'b1
  } req_type_t;

  typedef enum logic {
    CFG_ITER_LIMIT = 1'b0,
    CFG_TOLERANCE  = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    REASON_NONE      = 2'd0,
    REASON_CONVERGED = 2'd1,
    REASON_ITER_MAX  = 2'd2,
    REASON_DAMP_MAX  = 2'd3
  } stop_reason_t;

  typedef struct packed {
    logic                  stop;
    logic                  revert;
    logic                  lm_active;
    logic [DAMP_BITS-1:0]  damping_code;
    logic [ITER_BITS-1:0]  iteration;
    stop_reason_t          stop_reason;
  } result_t;

endpackage

/* rtl/lm_damping_convergence_detector.sv */
`timescale 1ns / 1ps

// channel  | dir | handshake          | payload
// s        | in  | s_tvalid/s_tready  | s_tuser: req_type; s_tdata: energy (signed Q31.16)
// m        | out | m_tvalid/m_tready  | m_tdata: stop, revert, lm_active, damping_code,
//          |     |                    |          iteration, stop_reason
// cfg      | in  | cfg_we             | cfg_index, cfg_data (iteration limit, tolerance)
//
// one word per clock while m_tready stays high; each word passes the input register
// and then the result register; the compare, subtract and state update sit between
// the two registers, with the state fed back to the next word
// rst is synchronous: state and valid flags clear, config registers load their defaults
// a stalled m side holds the result register; s_tready drops only when both
// the input register and the result register are full

module lm_damping_convergence_detector
  import lmdc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,   // [47:0] energy
  input  logic                     s_tuser,   // [0] req_type
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,   // [0] stop, [1] revert, [2] lm_active,
                                              // [6:3] damping_code, [22:7] iteration,
                                              // [24:23] stop_reason, [31:25] zero
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_data
);

  logic [MAXIT_BITS-1:0] iter_limit;
  logic [TOL_BITS-1:0]   tolerance;

  // input register
  logic                          in_valid;
  req_type_t                     in_req;
  logic signed [ENERGY_BITS-1:0] in_energy;

  // solver state
  logic signed [ENERGY_BITS-1:0] prev_energy, prev_energy_next;
  logic [COUNT_BITS-1:0]         iter_count, iter_count_next;
  logic                          lm_mode, lm_mode_next;
  logic [DAMP_BITS-1:0]          damping, damping_next;
  logic                          revert_flag, revert_flag_next;

  // result register
  logic    out_valid;
  result_t out_res;
  result_t res_next;

  logic                 advance;
  logic                 dropped, rose, at_limit;
  logic [DIFF_BITS-1:0] absdiff;
  logic                 stop_next;
  stop_reason_t         reason_next;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_DATA_BITS - $bits(result_t)){1'b0}},
                     out_res.stop_reason, out_res.iteration, out_res.damping_code,
                     out_res.lm_active, out_res.revert, out_res.stop};

  always_comb begin
    dropped  = in_energy < prev_energy;
    rose     = in_energy > prev_energy;
    absdiff  = dropped ? DIFF_BITS'({prev_energy[ENERGY_BITS-1], prev_energy}
                                    - {in_energy[ENERGY_BITS-1], in_energy})
                       : DIFF_BITS'({in_energy[ENERGY_BITS-1], in_energy}
                                    - {prev_energy[ENERGY_BITS-1], prev_energy});
    at_limit = CMP_BITS'(iter_count) >= CMP_BITS'(iter_limit);

    prev_energy_next = prev_energy;
    iter_count_next  = iter_count;
    lm_mode_next     = lm_mode;
    damping_next     = damping;
    revert_flag_next = revert_flag;
    stop_next        = 1'b0;
    reason_next      = REASON_NONE;

    unique case (in_req)
      REQ_RESTART: begin
        prev_energy_next = in_energy;
        iter_count_next  = '0;
        lm_mode_next     = 1'b0;
        damping_next     = DAMP_NONE;
        revert_flag_next = 1'b0;
      end
      REQ_TEST: begin
        if (!lm_mode) begin
          priority if (dropped) begin
            lm_mode_next     = 1'b1;
            revert_flag_next = 1'b1;
            damping_next     = DAMP_START;
          end else if (absdiff < DIFF_BITS'(tolerance)) begin
            stop_next        = 1'b1;
            reason_next      = REASON_CONVERGED;
            revert_flag_next = 1'b0;
          end else if (at_limit) begin
            stop_next        = 1'b1;
            reason_next      = REASON_ITER_MAX;
            revert_flag_next = 1'b0;
          end else begin
            prev_energy_next = in_energy;
            if (iter_count != '1) iter_count_next = iter_count + 1'b1;
          end
        end else begin
          priority if (rose) begin
            if (damping <= DAMP_START) lm_mode_next = 1'b0;
            else damping_next = damping - 1'b1;
            revert_flag_next = 1'b0;
            prev_energy_next = in_energy;
            if (iter_count != '1) iter_count_next = iter_count + 1'b1;
          end else if (damping >= DAMP_MAX) begin
            stop_next        = 1'b1;
            reason_next      = REASON_DAMP_MAX;
            revert_flag_next = 1'b1;
          end else if (at_limit) begin
            stop_next        = 1'b1;
            reason_next      = REASON_ITER_MAX;
            revert_flag_next = 1'b0;
          end else begin
            damping_next     = damping + 1'b1;
            revert_flag_next = 1'b1;
          end
        end
      end
      default: ;
    endcase

    res_next.stop         = stop_next;
    res_next.revert       = revert_flag_next;
    res_next.lm_active    = lm_mode_next;
    res_next.damping_code = damping_next;
    res_next.iteration    = ITER_BITS'(iter_count_next);
    res_next.stop_reason  = reason_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iter_limit <= MAXIT_RESET;
      tolerance  <= TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ITER_LIMIT: iter_limit <= cfg_data[MAXIT_BITS-1:0];
        CFG_TOLERANCE:  tolerance  <= cfg_data[TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      prev_energy <= '0;
      iter_count  <= '0;
      lm_mode     <= 1'b0;
      damping     <= DAMP_NONE;
      revert_flag <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid   <= 1'b1;
        prev_energy <= prev_energy_next;
        iter_count  <= iter_count_next;
        lm_mode     <= lm_mode_next;
        damping     <= damping_next;
        revert_flag <= revert_flag_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req    <= req_type_t'(s_tuser);
      in_energy <= s_tdata[ENERGY_BITS-1:0];
    end
    if (advance) begin
      out_res <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_reason_matches_stop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.stop == (out_res.stop_reason != REASON_NONE)))
    else $error("stop_reason disagrees with stop");

  a_lm_has_damping: assert property (@(posedge clk) disable iff (rst)
    lm_mode |-> (damping != DAMP_NONE))
    else $error("lm mode with no damping");

  a_damping_bounded: assert property (@(posedge clk) disable iff (rst)
    damping <= DAMP_MAX)
    else $error("damping code above maximum");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (iter_count == $past(iter_count) || iter_count == '0
              || iter_count == $past(iter_count) + 1'b1))
    else $error("iteration count jumped");

  a_state_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(lm_mode) && $stable(damping) && $stable(iter_count)))
    else $error("state changed without a word moving");
`endif

endmodule

/* verif/lmdc_monitor.sv */
`timescale 1ns / 1ps

module lmdc_monitor
  import lmdc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,   // [47:0] energy
  input  logic                     s_tuser,   // [0] req_type
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [OUT_DATA_BITS-1:0] m_tdata,   // [0] stop, [1] revert, [2] lm_active,
                                              // [6:3] damping_code, [22:7] iteration,
                                              // [24:23] stop_reason, [31:25] zero
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_data,
  output int                       mismatches,
  output int                       outstanding
);

  logic [MAXIT_BITS-1:0]         iter_limit;
  logic [TOL_BITS-1:0]           tol;
  logic signed [ENERGY_BITS-1:0] best_energy;
  logic [COUNT_BITS-1:0]         iter_count;
  logic                          lm_on;
  logic [DAMP_BITS-1:0]          damp;
  logic                          revert_on;
  result_t                       pending_results[$];

  function automatic result_t damping_step(input req_type_t req,
                                           input logic signed [ENERGY_BITS-1:0] e);
    result_t r;
    logic dropped;
    logic rose;
    logic at_limit;
    logic [DIFF_BITS-1:0] change;
    r.stop = 1'b0;
    r.stop_reason = REASON_NONE;
    if (req == REQ_RESTART) begin
      best_energy = e;
      iter_count = '0;
      lm_on = 1'b0;
      damp = DAMP_NONE;
      revert_on = 1'b0;
    end else begin
      dropped = e < best_energy;
      rose = e > best_energy;
      // one extra bit holds the full span between two signed energies
      change = dropped ? {best_energy[ENERGY_BITS-1], best_energy} - {e[ENERGY_BITS-1], e}
                       : {e[ENERGY_BITS-1], e} - {best_energy[ENERGY_BITS-1], best_energy};
      at_limit = iter_count >= iter_limit;
      if (!lm_on) begin
        if (dropped) begin
          lm_on = 1'b1;
          revert_on = 1'b1;
          damp = DAMP_START;
        end else if (change < {2'b00, tol}) begin
          r.stop = 1'b1;
          r.stop_reason = REASON_CONVERGED;
          revert_on = 1'b0;
        end else if (at_limit) begin
          r.stop = 1'b1;
          r.stop_reason = REASON_ITER_MAX;
          revert_on = 1'b0;
        end else begin
          best_energy = e;
          if (iter_count != '1) iter_count = iter_count + 1'b1;
        end
      end else begin
        // an equal value in lm mode falls through as a drop
        if (rose) begin
          if (damp <= DAMP_START) lm_on = 1'b0;
          else damp = damp - 1'b1;
          revert_on = 1'b0;
          best_energy = e;
          if (iter_count != '1) iter_count = iter_count + 1'b1;
        end else if (damp >= DAMP_MAX) begin
          r.stop = 1'b1;
          r.stop_reason = REASON_DAMP_MAX;
          revert_on = 1'b1;
        end else if (at_limit) begin
          r.stop = 1'b1;
          r.stop_reason = REASON_ITER_MAX;
          revert_on = 1'b0;
        end else begin
          damp = damp + 1'b1;
          revert_on = 1'b1;
        end
      end
    end
    r.revert = revert_on;
    r.lm_active = lm_on;
    r.damping_code = damp;
    r.iteration = ITER_BITS'(iter_count);
    return r;
  endfunction

  task automatic compare_field(input string name, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      iter_limit = MAXIT_RESET;
      tol = TOL_RESET;
      best_energy = '0;
      iter_count = '0;
      lm_on = 1'b0;
      damp = DAMP_NONE;
      revert_on = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_ITER_LIMIT: iter_limit = cfg_data[MAXIT_BITS-1:0];
          CFG_TOLERANCE:  tol = cfg_data[TOL_BITS-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(damping_step(req_type_t'(s_tuser), s_tdata));
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("result word %h with nothing expected", m_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("stop", want.stop, m_tdata[0]);
          compare_field("revert", want.revert, m_tdata[1]);
          compare_field("lm_active", want.lm_active, m_tdata[2]);
          compare_field("damping_code", want.damping_code, m_tdata[6:3]);
          compare_field("iteration", want.iteration, m_tdata[22:7]);
          compare_field("stop_reason", want.stop_reason, m_tdata[24:23]);
          compare_field("pad", 0, m_tdata[31:25]);
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

/* verif/tb_lm_damping_convergence_detector.sv */
`timescale 1ns / 1ps

module tb_lm_damping_convergence_detector;
  import lmdc_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 6;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;   // [47:0] energy
  logic                     s_tuser = 1'b0; // [0] req_type
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;        // [0] stop, [1] revert, [2] lm_active,
                                            // [6:3] damping_code, [22:7] iteration,
                                            // [24:23] stop_reason, [31:25] zero
  logic                     cfg_we = 1'b0;
  logic                     cfg_index = 1'b0;
  logic [CFG_BITS-1:0]      cfg_data = '0;

  int                            mismatches;
  int                            outstanding;
  int                            send_idle = 0;
  int                            sink_idle = 0;
  int                            quiet_cycles = 0;
  bit                            hold_req = 1'b0;
  logic signed [ENERGY_BITS-1:0] base_energy = '0;
  logic [TOL_BITS-1:0]           tol_now = TOL_RESET;

  lm_damping_convergence_detector uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lmdc_monitor mon (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random backpressure, or one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle);
      end
    end
  end

  function automatic logic [ENERGY_BITS-1:0] any_energy();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ENERGY_BITS-1:0];
  endfunction

  function automatic logic [ENERGY_BITS-1:0] step_size();
    logic [ENERGY_BITS-1:0] s;
    case ($urandom_range(2))
      0: s = ENERGY_BITS'($urandom_range(1, 1000));
      1: s = ENERGY_BITS'(tol_now) + ENERGY_BITS'($urandom_range(0, 100));
      default: s = any_energy() >> $urandom_range(0, ENERGY_BITS - 1);
    endcase
    return (s == '0) ? ENERGY_BITS'(1) : s;
  endfunction

  task automatic send_word(input req_type_t req, input logic [ENERGY_BITS-1:0] e);
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= e;
    do @(posedge clk); while (!s_tready);
    // idle cycle by cycle so the sender is idle in about send_idle of a hundred
    if ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_limits(input logic [MAXIT_BITS-1:0] iters,
                             input logic [TOL_BITS-1:0] tolerance);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_ITER_LIMIT;
    cfg_data <= CFG_BITS'(iters);
    @(posedge clk);
    cfg_index <= CFG_TOLERANCE;
    cfg_data <= tolerance;
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_now = tolerance;
  endtask

  // runs of drops, rises, equal and near values around a tracked best energy,
  // with some noise and restarts mixed in
  task automatic send_random(input int count);
    int left;
    int run;
    int kind;
    logic [ENERGY_BITS-1:0] e;
    longint unsigned near;
    left = count;
    while (left > 0) begin
      kind = $urandom_range(99);
      run = (kind < 30) ? $urandom_range(1, 14) : $urandom_range(1, 4);
      repeat (run) begin
        if (left == 0) break;
        if (kind < 30) begin
          send_word(REQ_TEST, base_energy - step_size());
        end else if (kind < 65) begin
          base_energy = base_energy + step_size();
          send_word(REQ_TEST, base_energy);
        end else if (kind < 75) begin
          send_word(REQ_TEST, base_energy);
        end else if (kind < 85) begin
          near = (tol_now == 0) ? 0 : {$urandom, $urandom} % tol_now;
          e = $urandom_range(1) ? base_energy + ENERGY_BITS'(near)
                                : base_energy - ENERGY_BITS'(near);
          send_word(REQ_TEST, e);
        end else if (kind < 93) begin
          base_energy = any_energy();
          send_word(req_type_t'($urandom_range(1)), base_energy);
        end else begin
          base_energy = $urandom_range(1) ? any_energy()
                                          : ENERGY_BITS'($urandom_range(0, 5000));
          send_word(REQ_RESTART, base_energy);
        end
        left--;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, default limits
    send_word(REQ_RESTART, '0);
    send_word(REQ_TEST, '0);                    // equal outside lm mode converges
    send_word(REQ_TEST, ENERGY_BITS'(100));     // small rise converges
    send_word(REQ_TEST, ENERGY_BITS'(1000));    // rise, one iteration
    send_word(REQ_TEST, ENERGY_BITS'(500));     // drop enters lm mode
    send_word(REQ_TEST, ENERGY_BITS'(500));     // equal in lm mode raises damping
    send_word(REQ_TEST, ENERGY_BITS'(9000));    // rise lowers damping
    send_word(REQ_TEST, ENERGY_BITS'(9500));    // rise at start damping leaves lm mode
    for (int k = 1; k <= 14; k++) // climb to maximum damping, then stop there
      send_word(REQ_TEST, ENERGY_BITS'(9500 - 10 * k));
    send_word(REQ_RESTART, 48'h7FFF_FFFF_FFFF);
    send_word(REQ_TEST, 48'h8000_0000_0000);
    send_word(REQ_RESTART, 48'h8000_0000_0000);
    send_word(REQ_TEST, 48'h7FFF_FFFF_FFFF);

    send_idle = 33;
    sink_idle = 69;
    load_limits(16'd3, 47'd65536);
    send_random(250);
    load_limits(16'd0, 47'd1);
    hold_req = 1'b1;
    send_random(100);

    send_idle = 69;
    sink_idle = 33;
    load_limits(16'hFFFF, 47'h7FFF_FFFF_FFFF);
    send_random(150);
    load_limits(16'd5, TOL_BITS'($urandom_range(1, 5000)));
    send_random(120);
    wait_for_results();
    send_random(130);

    send_idle = 0;
    sink_idle = 0;
    load_limits(16'd1, 47'd0);
    send_random(150);
    load_limits(16'd20, 47'd655);
    send_random(200);

    wait_for_results();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lmdc_pkg.sv
rtl/lm_damping_convergence_detector.sv
verif/lmdc_monitor.sv
verif/tb_lm_damping_convergence_detector.sv
